// ----- hdl/prt_pkg.sv -----
// Shared types and constants for the pending request tracker.
// No dependencies; imported by every module of the block.
package prt_pkg;

  localparam logic [1:0] CMD_SEND  = 2'd0;
  localparam logic [1:0] CMD_RESP  = 2'd1;
  localparam logic [1:0] CMD_CHECK = 2'd2;

  localparam logic [31:0] TIMEOUT_RESET = 32'd5000;
  localparam logic [7:0]  COUNT_MAX     = 8'd255;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] query_id;
    logic [31:0] now_ms;
    logic        immediate;
  } item_t;

  typedef struct packed {
    logic        found;
    logic [31:0] rtt_ms;
    logic [7:0]  pending_count;
    logic [31:0] next_timeout_ms;
    logic        has_next;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic send;
    logic issue;
    logic load;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic more;
    logic hit;
    logic eval_v;
    logic out_free;
  } ctrl_status_t;

endpackage

// ----- hdl/prt_datapath.sv -----
// Datapath: slot memories, valid bits, ring pointers, walk pipeline, result register.
// Depends on prt_pkg.
module prt_datapath import prt_pkg::*; #(
  parameter int RING_SLOTS = 32
) (
  input  logic         clk,
  input  logic         rst,
  input  item_t        item,
  input  logic         cfg_we,
  input  logic [31:0]  cfg_data,
  input  ctrl_cmd_t    cmd,
  output ctrl_status_t status,
  output logic         result_valid,
  input  logic         result_ready,
  output result_t      result
);

  localparam int IW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int LW = $clog2(RING_SLOTS + 1);
  localparam int SW = LW + 1;
  localparam logic [SW-1:0] SLOTS = SW'(RING_SLOTS);
  localparam logic [LW-1:0] FULL  = LW'(RING_SLOTS);

  logic [15:0] mem_id   [RING_SLOTS];
  logic [31:0] mem_time [RING_SLOTS];

  logic [31:0]           timeout;
  logic [IW-1:0]         oldest;
  logic [LW-1:0]         ring_len;
  logic [7:0]            unanswered;
  logic [LW-1:0]         cnt;
  logic [RING_SLOTS-1:0] slot_valid;
  item_t                 cur;
  logic                  eval_v;
  logic [IW-1:0]         eval_pos;
  logic [15:0]           rd_id;
  logic [31:0]           rd_time;
  logic                  found;
  logic [31:0]           rtt;
  logic [7:0]            live;
  logic                  has_next;
  logic [31:0]           next_to;

  logic [LW-1:0] offset;
  logic [SW-1:0] sum;
  logic [IW-1:0] pos;
  logic [31:0]   age;
  logic          hit;
  logic          live_hit;
  logic [7:0]    pending;

  assign offset = cmd.send ? ring_len : cnt;
  assign sum    = SW'(oldest) + SW'(offset);
  assign pos    = (sum >= SLOTS) ? IW'(sum - SLOTS) : IW'(sum);

  assign age      = cur.now_ms - rd_time;
  assign hit      = eval_v && (cur.cmd == CMD_RESP) && slot_valid[eval_pos]
                    && (rd_id == cur.query_id);
  assign live_hit = eval_v && (cur.cmd == CMD_CHECK) && slot_valid[eval_pos]
                    && (age <= timeout);
  assign pending  = (cur.cmd == CMD_CHECK) ? live : unanswered;

  assign status.more     = cnt < ring_len;
  assign status.hit      = hit;
  assign status.eval_v   = eval_v;
  assign status.out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (cmd.send) begin
      mem_id[pos]   <= cur.query_id;
      mem_time[pos] <= cur.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    rd_id   <= mem_id[pos];
    rd_time <= mem_time[pos];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout      <= TIMEOUT_RESET;
      oldest       <= '0;
      ring_len     <= '0;
      unanswered   <= '0;
      slot_valid   <= '0;
      eval_v       <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout <= cfg_data;
      end
      eval_v <= cmd.issue;
      if (cmd.send) begin
        slot_valid[pos] <= 1'b1;
        if (ring_len == FULL) begin
          oldest <= (oldest == IW'(RING_SLOTS - 1)) ? '0 : oldest + 1'b1;
        end else begin
          ring_len <= ring_len + 1'b1;
        end
        if (unanswered != COUNT_MAX) begin
          unanswered <= unanswered + 1'b1;
        end
      end
      if (hit) begin
        slot_valid[eval_pos] <= 1'b0;
        if (unanswered != '0) begin
          unanswered <= unanswered - 1'b1;
        end
      end
      if (cmd.load) begin
        result_valid <= 1'b1;
        if (cur.cmd == CMD_CHECK) begin
          unanswered <= live;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur      <= item;
      cnt      <= '0;
      found    <= 1'b0;
      rtt      <= '0;
      live     <= '0;
      has_next <= 1'b0;
      next_to  <= '0;
    end else begin
      if (cmd.issue) begin
        cnt <= cnt + 1'b1;
      end
      if (hit) begin
        found <= 1'b1;
        rtt   <= cur.immediate ? age : '0;
      end
      if (live_hit) begin
        if (live != COUNT_MAX) begin
          live <= live + 1'b1;
        end
        if (!has_next) begin
          has_next <= 1'b1;
          next_to  <= timeout - age;
        end
      end
    end
    if (cmd.issue) begin
      eval_pos <= pos;
    end
    if (cmd.load) begin
      result.found           <= found;
      result.rtt_ms          <= rtt;
      result.pending_count   <= pending;
      result.next_timeout_ms <= next_to;
      result.has_next        <= has_next;
    end
  end

endmodule

// ----- hdl/prt_controller.sv -----
// Controller state machine: sequences send, ring walk and result load.
// Depends on prt_pkg.
module prt_controller import prt_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         item_valid,
  input  logic [1:0]   item_cmd,
  output logic         item_ready,
  input  ctrl_status_t status,
  output ctrl_cmd_t    cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SEND   = 2'd1;
  localparam logic [1:0] S_WALK   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign item_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.accept = item_valid;
        if (item_valid) begin
          case (item_cmd)
            CMD_SEND:  state_next = S_SEND;
            CMD_RESP:  state_next = S_WALK;
            CMD_CHECK: state_next = S_WALK;
            default:   state_next = S_FINISH;
          endcase
        end
      end
      S_SEND: begin
        cmd.send   = 1'b1;
        state_next = S_FINISH;
      end
      S_WALK: begin
        cmd.issue = status.more && !status.hit;
        if (status.hit || (!status.more && !status.eval_v)) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.load = status.out_free;
        if (status.out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/pending_request_tracker.sv -----
// Pending request tracker: ring of RING_SLOTS request slots (id, send time, valid).
// A send word writes its slot, then its result is loaded. A response or check word
// walks the live ring one slot per cycle through the registered slot memory read.
// A check, or a response that matches nothing, walks all ring_len entries before its
// result is loaded; a response that matches a valid slot ends the walk at that slot.
// Unused command codes go straight to the result load. The result register frees the
// input side: the next word is taken the cycle after a result is loaded, while it waits.
// timeout_ms is written through cfg_we/cfg_data; the user must write it only while the
// block is idle, as the block itself does not enforce this.
// Depends on prt_pkg, prt_controller, prt_datapath.
module pending_request_tracker import prt_pkg::*; #(
  parameter int RING_SLOTS = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_ready,
  input  item_t       item,
  output logic        result_valid,
  input  logic        result_ready,
  output result_t     result,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data
);

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  prt_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_cmd   (item.cmd),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  prt_datapath #(
    .RING_SLOTS (RING_SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

// ----- hdl/prt_checker.sv -----
// Port-level checks for the pending request tracker, bound to the top level.
// Depends on prt_pkg and pending_request_tracker.
module prt_checker import prt_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input result_t     result
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result word present right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result word changed");

  a_rtt_only_found: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.found |-> result.rtt_ms == '0)
    else $error("round-trip time without a match");

  a_next_only_live: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.has_next |-> result.next_timeout_ms == '0)
    else $error("next timeout without a live request");

  a_check_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.has_next |-> !result.found && result.pending_count != '0)
    else $error("check result inconsistent");

endmodule

bind pending_request_tracker prt_checker u_prt_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);
